[design/edaa_pkg.sv]
// Package for the enum discriminant assigner: widths, status codes, the
// controller state type and the token that walks the compare chain.
// No dependencies.
package edaa_pkg;

    localparam int VALUE_W      = 64;
    localparam int MAX_VARIANTS = 64;
    localparam int STATUS_W     = 3;
    localparam int S_TDATA_W    = 72;
    localparam int M_TDATA_W    = 136;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 3'd0,
        STATUS_NOT_INT      = 3'd1,
        STATUS_NEGATIVE     = 3'd2,
        STATUS_UNPARSABLE   = 3'd3,
        STATUS_MAX_NOT_LAST = 3'd4,
        STATUS_DUPLICATE    = 3'd5,
        STATUS_SKIPPED      = 3'd6,
        STATUS_STORE_FULL   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_FINAL
    } fsm_state_t;

    // Token handed from cell to cell during a duplicate search.
    typedef struct packed {
        logic vld;
        logic hit;
    } tok_t;

endpackage

[design/edaa_cell.sv]
// One storage cell of the seen-value chain: holds one discriminant with its
// valid bit and compares it against the probe as the search token passes.
// Depends on edaa_pkg.
module edaa_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic                          wr_en,
    input  logic [edaa_pkg::VALUE_W-1:0]  wr_data,
    input  logic [edaa_pkg::VALUE_W-1:0]  probe,
    input  edaa_pkg::tok_t                tok_in,
    output edaa_pkg::tok_t                tok_out
);

    logic [edaa_pkg::VALUE_W-1:0] stored_reg;
    logic                         valid_reg;
    logic                         valid_next;
    edaa_pkg::tok_t               tok_reg;
    edaa_pkg::tok_t               tok_next;

    always_comb begin
        if (clear) begin
            valid_next = 1'b0;
        end else if (wr_en) begin
            valid_next = 1'b1;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_comb begin
        tok_next.vld = tok_in.vld;
        tok_next.hit = tok_in.hit | (tok_in.vld & valid_reg & (stored_reg == probe));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stored_reg <= wr_data;
        end
    end

    assign tok_out = tok_reg;

endmodule

[design/edaa_chain.sv]
// Row of seen-value cells. The search token enters the first cell and moves
// one cell per cycle; a write lands in the cell picked by the fill count.
// Depends on edaa_pkg and edaa_cell.
module edaa_chain #(
    parameter int N     = edaa_pkg::MAX_VARIANTS,
    parameter int CNT_W = $clog2(N + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic                          wr_en,
    input  logic [CNT_W-1:0]              wr_idx,
    input  logic [edaa_pkg::VALUE_W-1:0]  value,
    input  edaa_pkg::tok_t                tok_in,
    output edaa_pkg::tok_t                tok_out
);

    edaa_pkg::tok_t tok_link [N+1];

    assign tok_link[0] = tok_in;

    for (genvar i = 0; i < N; i++) begin : g_cell
        edaa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clear   (clear),
            .wr_en   (wr_en && (wr_idx == CNT_W'(i))),
            .wr_data (value),
            .probe   (value),
            .tok_in  (tok_link[i]),
            .tok_out (tok_link[i+1])
        );
    end

    assign tok_out = tok_link[N];

endmodule

[design/enum_discriminant_assigner_unit.sv]
// Enum discriminant assigner, top level.
// m_tvalid comes from an output register loaded from FSM_FINAL. A variant that
// needs the duplicate search passes FSM_SEARCH and the chain's cell registers on
// the way; one that fails an earlier check goes straight to FSM_FINAL. One variant
// is in work at a time: a new word is taken only in FSM_IDLE.
// Reset (aresetn low, synchronous) clears all control state and the store.
module enum_discriminant_assigner_unit #(
    parameter int MAX_VARIANTS = edaa_pkg::MAX_VARIANTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // has_explicit, is_int_literal, is_negative, parse_ok, literal_value, zero pad
    input  logic [edaa_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, disc_value, max_value, zero pad
    output logic [edaa_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);

    localparam int CNT_W = $clog2(MAX_VARIANTS + 1);
    localparam int VW    = edaa_pkg::VALUE_W;

    edaa_pkg::fsm_state_t state_reg, state_next;

    logic [VW-1:0]        next_implicit_reg, next_implicit_next;
    logic [VW-1:0]        running_max_reg, running_max_next;
    logic [CNT_W-1:0]     seen_count_reg, seen_count_next;
    logic                 error_latched_reg, error_latched_next;

    logic [VW-1:0]        disc_reg;
    edaa_pkg::status_t    pre_status_reg;
    logic                 last_reg;
    logic                 hit_reg;
    logic                 launch_reg;

    logic                 out_valid_reg;
    edaa_pkg::status_t    out_status_reg;
    logic [VW-1:0]        out_disc_reg;
    logic [VW-1:0]        out_max_reg;
    logic                 out_last_reg;

    logic                 accept;
    logic                 finalize;
    logic                 slot_free;
    edaa_pkg::status_t    pre_status;
    logic [VW-1:0]        pre_disc;
    edaa_pkg::status_t    final_status;
    edaa_pkg::tok_t       chain_in;
    edaa_pkg::tok_t       chain_out;
    logic                 store_wr;

    logic                 in_explicit;
    logic                 in_int;
    logic                 in_neg;
    logic                 in_parsed;
    logic [VW-1:0]        in_literal;

    assign in_explicit = s_tdata[0];
    assign in_int      = s_tdata[1];
    assign in_neg      = s_tdata[2];
    assign in_parsed   = s_tdata[3];
    assign in_literal  = s_tdata[VW+3:4];

    // Checks that need no search, in priority order.
    always_comb begin
        pre_status = edaa_pkg::STATUS_OK;
        pre_disc   = next_implicit_reg;
        if (error_latched_reg) begin
            pre_status = edaa_pkg::STATUS_SKIPPED;
        end else if (in_explicit) begin
            if (!in_int) begin
                pre_status = edaa_pkg::STATUS_NOT_INT;
            end else if (in_neg) begin
                pre_status = edaa_pkg::STATUS_NEGATIVE;
            end else if (!in_parsed) begin
                pre_status = edaa_pkg::STATUS_UNPARSABLE;
            end else begin
                pre_disc = in_literal;
            end
        end
        if (pre_status == edaa_pkg::STATUS_OK && pre_disc == edaa_pkg::VALUE_MAX &&
                !s_tlast) begin
            pre_status = edaa_pkg::STATUS_MAX_NOT_LAST;
        end
    end

    always_comb begin
        if (pre_status_reg != edaa_pkg::STATUS_OK) begin
            final_status = pre_status_reg;
        end else if (hit_reg) begin
            final_status = edaa_pkg::STATUS_DUPLICATE;
        end else if (seen_count_reg >= CNT_W'(MAX_VARIANTS)) begin
            final_status = edaa_pkg::STATUS_STORE_FULL;
        end else begin
            final_status = edaa_pkg::STATUS_OK;
        end
    end

    assign slot_free = !out_valid_reg || m_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            edaa_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = (pre_status == edaa_pkg::STATUS_OK) ?
                                 edaa_pkg::FSM_SEARCH : edaa_pkg::FSM_FINAL;
                end
            end
            edaa_pkg::FSM_SEARCH: begin
                if (chain_out.vld) begin
                    state_next = edaa_pkg::FSM_FINAL;
                end
            end
            edaa_pkg::FSM_FINAL: begin
                if (slot_free) begin
                    state_next = edaa_pkg::FSM_IDLE;
                end
            end
            default: state_next = edaa_pkg::FSM_IDLE;
        endcase
    end

    // Output decode of the controller.
    always_comb begin
        s_tready = 1'b0;
        finalize = 1'b0;
        unique case (state_reg)
            edaa_pkg::FSM_IDLE:   s_tready = 1'b1;
            edaa_pkg::FSM_SEARCH: ;
            edaa_pkg::FSM_FINAL:  finalize = slot_free;
            default: ;
        endcase
    end

    assign accept       = s_tvalid && s_tready;
    assign store_wr     = finalize && (final_status == edaa_pkg::STATUS_OK);
    assign chain_in.vld = launch_reg;
    assign chain_in.hit = 1'b0;

    // Enum state update at the end of each variant.
    always_comb begin
        next_implicit_next = next_implicit_reg;
        running_max_next   = running_max_reg;
        seen_count_next    = seen_count_reg;
        error_latched_next = error_latched_reg;
        if (finalize) begin
            if (final_status == edaa_pkg::STATUS_OK) begin
                next_implicit_next = disc_reg + VW'(1);
                seen_count_next    = seen_count_reg + CNT_W'(1);
                if (disc_reg > running_max_reg) begin
                    running_max_next = disc_reg;
                end
            end else begin
                error_latched_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= edaa_pkg::FSM_IDLE;
            next_implicit_reg <= '0;
            running_max_reg   <= '0;
            seen_count_reg    <= '0;
            error_latched_reg <= 1'b0;
            launch_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= accept && (pre_status == edaa_pkg::STATUS_OK);
            if (finalize && last_reg) begin
                next_implicit_reg <= '0;
                running_max_reg   <= '0;
                seen_count_reg    <= '0;
                error_latched_reg <= 1'b0;
            end else begin
                next_implicit_reg <= next_implicit_next;
                running_max_reg   <= running_max_next;
                seen_count_reg    <= seen_count_next;
                error_latched_reg <= error_latched_next;
            end
            if (finalize) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            disc_reg       <= pre_disc;
            pre_status_reg <= pre_status;
            last_reg       <= s_tlast;
            hit_reg        <= 1'b0;
        end else if (chain_out.vld) begin
            hit_reg <= chain_out.hit;
        end
        if (finalize) begin
            out_status_reg <= final_status;
            out_disc_reg   <= (final_status == edaa_pkg::STATUS_OK) ? disc_reg : '0;
            out_max_reg    <= running_max_next;
            out_last_reg   <= last_reg;
        end
    end

    edaa_chain #(
        .N     (MAX_VARIANTS),
        .CNT_W (CNT_W)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (finalize && last_reg),
        .wr_en   (store_wr && !last_reg),
        .wr_idx  (seen_count_reg),
        .value   (disc_reg),
        .tok_in  (chain_in),
        .tok_out (chain_out)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(edaa_pkg::M_TDATA_W - edaa_pkg::STATUS_W - 2*VW){1'b0}},
                       out_max_reg, out_disc_reg, out_status_reg};

endmodule
